### design/jprc_pkg.sv
package jprc_pkg;

	// Store geometry
	localparam int MAX_BYTES  = 4096;
	localparam int PAIR_DEPTH = MAX_BYTES / 2;
	localparam int IDX_W      = $clog2(MAX_BYTES);
	localparam int PAIR_W     = $clog2(PAIR_DEPTH);
	localparam int CNT_W      = $clog2(MAX_BYTES + 2);
	localparam int PCNT_W     = $clog2(PAIR_DEPTH + 1);

	// Field widths
	localparam int LEN_W      = 13;
	localparam int CFG_W      = 13;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	// Constants
	localparam logic [31:0]      CRC_POLY     = 32'hEDB88320;
	localparam logic [31:0]      CRC_PRESET   = 32'hFFFFFFFF;
	localparam logic [7:0]       RUN_CAP      = 8'd255;
	localparam logic [CFG_W-1:0] PACK_FLOOR   = 13'd16;
	localparam logic [CFG_W-1:0] CFG_MIN_RST  = 13'd64;
	localparam logic [PADDR_W-1:0] CFG_MIN_ADDR = 3'd0;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_READ = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_TOO_LONG = 2'd1,
		ST_RANGE    = 2'd2
	} status_t;

	// Store write requests from the encoder
	typedef struct packed {
		logic              raw_we;
		logic [IDX_W-1:0]  raw_addr;
		logic [7:0]        raw_data;
		logic              pair_we;
		logic [PAIR_W-1:0] pair_addr;
		logic [15:0]       pair_data;
		logic              tail_we;
		logic [PAIR_W-1:0] tail_addr;
		logic [15:0]       tail_data;
	} store_wr_t;

	// End-of-payload summary
	typedef struct packed {
		status_t           status;
		logic [LEN_W-1:0]  length;
		logic              compressed;
		logic [31:0]       crc;
	} summary_t;

	// Reflected CRC-32, one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	// Reflected CRC-32 over a (value, count) pair
	function automatic logic [31:0] crc_pair(input logic [31:0] c, input logic [7:0] v,
		input logic [7:0] n);
		return crc_byte(crc_byte(c, v), n);
	endfunction

endpackage

### design/jprc_apb.sv
module jprc_apb (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [jprc_pkg::PADDR_W-1:0]      paddr,
	input  logic [jprc_pkg::PDATA_W-1:0]      pwdata,
	output logic [jprc_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready,
	output logic [jprc_pkg::CFG_W-1:0]        cfg_min
);

	logic [jprc_pkg::CFG_W-1:0] cfg_min_q;

	// Write the threshold register on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_min_q <= jprc_pkg::CFG_MIN_RST;
		end else if (psel && penable && pwrite && paddr == jprc_pkg::CFG_MIN_ADDR) begin
			cfg_min_q <= pwdata[jprc_pkg::CFG_W-1:0];
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		if (paddr == jprc_pkg::CFG_MIN_ADDR) begin
			prdata = jprc_pkg::PDATA_W'(cfg_min_q);
		end
	end

	assign pready  = 1'b1;
	assign cfg_min = cfg_min_q;

endmodule

### design/jprc_encoder.sv
module jprc_encoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  jprc_pkg::opcode_t             op,
	input  logic [7:0]                    din,
	input  logic                          last,
	input  logic [jprc_pkg::CFG_W-1:0]    cfg_min,
	output jprc_pkg::store_wr_t           wr,
	output jprc_pkg::summary_t            sum,
	output logic [jprc_pkg::LEN_W-1:0]    res_len,
	output logic                          res_pk
);

	localparam int CNT_W  = jprc_pkg::CNT_W;
	localparam int PCNT_W = jprc_pkg::PCNT_W;

	logic [CNT_W-1:0]  raw_cnt_q;
	logic [PCNT_W-1:0] pair_cnt_q;
	logic              ovf_q;
	logic [7:0]        run_val_q;
	logic [7:0]        run_len_q;
	logic [31:0]       raw_crc_q;
	logic [31:0]       pk_crc_q;
	logic [jprc_pkg::LEN_W-1:0] res_len_q;
	logic              res_pk_q;

	logic              load_go;
	logic              room;
	logic [CNT_W-1:0]  raw_cnt_n;
	logic              run_open;
	logic              close_run;
	logic              start_run;
	logic              push1;
	logic              push2;
	logic              ovf1;
	logic              ovf2;
	logic [PCNT_W-1:0] pairs1;
	logic [PCNT_W-1:0] pairs2;
	logic [31:0]       crc1;
	logic [31:0]       crc2;
	logic [31:0]       raw_crc_n;
	logic [7:0]        run_val_n;
	logic [7:0]        run_len_n;
	logic              too_long;
	logic [CNT_W-1:0]  thr;
	logic [CNT_W-1:0]  pk_bytes;
	logic              use_pk;

	assign load_go = adv && op == jprc_pkg::OP_LOAD;

	// Run tracking, pair pushes and both CRCs for one byte
	always_comb begin
		room      = raw_cnt_q < CNT_W'(jprc_pkg::MAX_BYTES);
		raw_cnt_n = room ? raw_cnt_q + CNT_W'(1) : CNT_W'(jprc_pkg::MAX_BYTES + 1);
		raw_crc_n = room ? jprc_pkg::crc_byte(raw_crc_q, din) : raw_crc_q;
		run_open  = run_len_q != 8'd0;
		close_run = room && run_open && (din != run_val_q || run_len_q == jprc_pkg::RUN_CAP);

		// pair closed by this byte
		push1  = close_run && !ovf_q && pair_cnt_q < PCNT_W'(jprc_pkg::PAIR_DEPTH);
		ovf1   = ovf_q || (close_run && !(pair_cnt_q < PCNT_W'(jprc_pkg::PAIR_DEPTH)));
		pairs1 = pair_cnt_q + PCNT_W'(push1);
		crc1   = push1 ? jprc_pkg::crc_pair(pk_crc_q, run_val_q, run_len_q) : pk_crc_q;

		start_run = close_run || !run_open;
		run_val_n = run_val_q;
		run_len_n = run_len_q;
		if (room) begin
			run_val_n = start_run ? din : run_val_q;
			run_len_n = start_run ? 8'd1 : run_len_q + 8'd1;
		end

		// final pair flushed at the end of the payload
		too_long = raw_cnt_n > CNT_W'(jprc_pkg::MAX_BYTES);
		push2    = !too_long && run_len_n != 8'd0 && !ovf1
			&& pairs1 < PCNT_W'(jprc_pkg::PAIR_DEPTH);
		ovf2     = ovf1 || (!too_long && run_len_n != 8'd0
			&& !(pairs1 < PCNT_W'(jprc_pkg::PAIR_DEPTH)));
		pairs2   = pairs1 + PCNT_W'(push2);
		crc2     = push2 ? jprc_pkg::crc_pair(crc1, run_val_n, run_len_n) : crc1;

		// choose the stored form
		thr      = (cfg_min < jprc_pkg::PACK_FLOOR) ? CNT_W'(jprc_pkg::PACK_FLOOR)
			: CNT_W'(cfg_min);
		pk_bytes = CNT_W'({pairs2, 1'b0});
		use_pk   = !too_long && raw_cnt_n >= thr && !ovf2 && pk_bytes < raw_cnt_n;

		sum.status     = too_long ? jprc_pkg::ST_TOO_LONG : jprc_pkg::ST_OK;
		sum.compressed = use_pk;
		sum.length     = too_long ? '0
			: jprc_pkg::LEN_W'(use_pk ? pk_bytes : raw_cnt_n);
		sum.crc        = too_long ? 32'd0 : ~(use_pk ? crc2 : raw_crc_n);
	end

	// Store writes
	always_comb begin
		wr.raw_we    = load_go && room;
		wr.raw_addr  = raw_cnt_q[jprc_pkg::IDX_W-1:0];
		wr.raw_data  = din;
		wr.pair_we   = load_go && push1;
		wr.pair_addr = pair_cnt_q[jprc_pkg::PAIR_W-1:0];
		wr.pair_data = {run_val_q, run_len_q};
		wr.tail_we   = load_go && last && push2;
		wr.tail_addr = pairs1[jprc_pkg::PAIR_W-1:0];
		wr.tail_data = {run_val_n, run_len_n};
	end

	// Advance payload state; clear it and latch the result on the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_cnt_q  <= '0;
			pair_cnt_q <= '0;
			ovf_q      <= 1'b0;
			run_val_q  <= 8'd0;
			run_len_q  <= 8'd0;
			raw_crc_q  <= jprc_pkg::CRC_PRESET;
			pk_crc_q   <= jprc_pkg::CRC_PRESET;
			res_len_q  <= '0;
			res_pk_q   <= 1'b0;
		end else if (load_go) begin
			if (last) begin
				raw_cnt_q  <= '0;
				pair_cnt_q <= '0;
				ovf_q      <= 1'b0;
				run_val_q  <= 8'd0;
				run_len_q  <= 8'd0;
				raw_crc_q  <= jprc_pkg::CRC_PRESET;
				pk_crc_q   <= jprc_pkg::CRC_PRESET;
				res_len_q  <= sum.length;
				res_pk_q   <= use_pk;
			end else begin
				raw_cnt_q  <= raw_cnt_n;
				pair_cnt_q <= pairs1;
				ovf_q      <= ovf1;
				run_val_q  <= run_val_n;
				run_len_q  <= run_len_n;
				raw_crc_q  <= raw_crc_n;
				pk_crc_q   <= crc1;
			end
		end
	end

	assign res_len = res_len_q;
	assign res_pk  = res_pk_q;

endmodule

### design/jprc_store.sv
module jprc_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  jprc_pkg::store_wr_t           wr,
	input  logic                          adv,
	input  logic [jprc_pkg::IDX_W-1:0]    rd_idx,
	output logic [7:0]                    raw_rd,
	output logic [15:0]                   pair_rd
);

	logic [7:0]  raw_mem  [jprc_pkg::MAX_BYTES];
	logic [15:0] pair_mem [jprc_pkg::PAIR_DEPTH];

	logic [7:0]                  raw_rd_q;
	logic [15:0]                 pair_rd_q;
	logic                        pend_v_q;
	logic [jprc_pkg::PAIR_W-1:0] pend_addr_q;
	logic [15:0]                 pend_data_q;

	logic                        pair_wen;
	logic [jprc_pkg::PAIR_W-1:0] pair_waddr;
	logic [15:0]                 pair_wdata;
	logic [jprc_pkg::PAIR_W-1:0] rd_pair;

	assign rd_pair = rd_idx[jprc_pkg::IDX_W-1:1];

	// Raw byte store
	always_ff @(posedge clk) begin
		if (wr.raw_we) begin
			raw_mem[wr.raw_addr] <= wr.raw_data;
		end
		if (adv) begin
			raw_rd_q <= raw_mem[rd_idx];
		end
	end

	// Drain the deferred tail pair first; the cycle after a last byte has no push
	always_comb begin
		pair_wen   = pend_v_q || wr.pair_we;
		pair_waddr = pend_v_q ? pend_addr_q : wr.pair_addr;
		pair_wdata = pend_v_q ? pend_data_q : wr.pair_data;
	end

	// Pair store, with bypass of the tail pair still waiting to be written
	always_ff @(posedge clk) begin
		if (pair_wen) begin
			pair_mem[pair_waddr] <= pair_wdata;
		end
		if (adv) begin
			pair_rd_q <= (pend_v_q && pend_addr_q == rd_pair) ? pend_data_q
				: pair_mem[rd_pair];
		end
	end

	// Register the tail pair until it drains into the pair store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else begin
			pend_v_q <= wr.tail_we;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.tail_we) begin
			pend_addr_q <= wr.tail_addr;
			pend_data_q <= wr.tail_data;
		end
	end

	assign raw_rd  = raw_rd_q;
	assign pair_rd = pair_rd_q;

`ifndef SYNTHESIS
	a_tail_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> !wr.pair_we)
		else $error("tail pair drain collides with a pair push");
`endif

endmodule

### design/journal_payload_rle_crc_packer.sv
// Items pass through the input register, then the result register; a held result stalls the input.
// Throughput: one item per cycle unless stalled; load bytes update counters, run state, both CRCs.
// A last byte folds up to four pair CRC bytes in one pass; the tail pair is stored in the next cycle.
// Reset clears counters and handshake state, presets both CRCs and sets the threshold to 64.
// Byte stores are not cleared; entries read back only after a payload has written them.
module journal_payload_rle_crc_packer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [jprc_pkg::PADDR_W-1:0]      paddr,
	input  logic [jprc_pkg::PDATA_W-1:0]      pwdata,
	output logic [jprc_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              opcode,
	input  logic [7:0]                        data_byte,
	input  logic                              last_byte,
	input  logic [11:0]                       read_index,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        status,
	output logic                              is_summary,
	output logic [7:0]                        stored_byte,
	output logic [12:0]                       stored_length,
	output logic                              compressed,
	output logic [31:0]                       crc_value
);

	logic [jprc_pkg::CFG_W-1:0] cfg_min;

	// input register
	logic                        s1_valid_q;
	jprc_pkg::opcode_t           op_s1;
	logic [7:0]                  din_s1;
	logic                        last_s1;
	logic [jprc_pkg::IDX_W-1:0]  idx_s1;

	// result register
	logic                        s2_valid_q;
	jprc_pkg::status_t           status_s2;
	logic                        summary_s2;
	logic [jprc_pkg::LEN_W-1:0]  len_s2;
	logic                        cmp_s2;
	logic [31:0]                 crc_s2;
	logic                        rd_ok_s2;
	logic                        odd_s2;

	logic                        adv;
	logic                        is_read;
	logic                        rd_ok;
	jprc_pkg::store_wr_t         wr;
	jprc_pkg::summary_t          sum;
	logic [jprc_pkg::LEN_W-1:0]  res_len;
	logic                        res_pk;
	logic [7:0]                  raw_rd;
	logic [15:0]                 pair_rd;

	jprc_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg_min (cfg_min)
	);

	jprc_encoder u_enc (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.op      (op_s1),
		.din     (din_s1),
		.last    (last_s1),
		.cfg_min (cfg_min),
		.wr      (wr),
		.sum     (sum),
		.res_len (res_len),
		.res_pk  (res_pk)
	);

	jprc_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.adv     (adv),
		.rd_idx  (idx_s1),
		.raw_rd  (raw_rd),
		.pair_rd (pair_rd)
	);

	// Advance when the result register is free or being drained
	assign adv      = s1_valid_q && (!s2_valid_q || out_ready);
	assign in_ready = !s1_valid_q || adv;
	assign is_read  = op_s1 == jprc_pkg::OP_READ;
	assign rd_ok    = jprc_pkg::LEN_W'(idx_s1) < res_len;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1   <= jprc_pkg::opcode_t'(opcode);
			din_s1  <= data_byte;
			last_s1 <= last_byte;
			idx_s1  <= read_index;
		end
	end

	// Result register valid: reads and last bytes produce a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (adv) begin
			s2_valid_q <= is_read || last_s1;
		end else if (out_ready) begin
			s2_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (adv) begin
			if (is_read) begin
				status_s2  <= rd_ok ? jprc_pkg::ST_OK : jprc_pkg::ST_RANGE;
				summary_s2 <= 1'b0;
				len_s2     <= res_len;
				cmp_s2     <= res_pk;
				crc_s2     <= 32'd0;
				rd_ok_s2   <= rd_ok;
				odd_s2     <= idx_s1[0];
			end else begin
				status_s2  <= sum.status;
				summary_s2 <= 1'b1;
				len_s2     <= sum.length;
				cmp_s2     <= sum.compressed;
				crc_s2     <= sum.crc;
				rd_ok_s2   <= 1'b0;
				odd_s2     <= 1'b0;
			end
		end
	end

	// Pick the stored byte: value at even index, count at odd index of a pair
	always_comb begin
		stored_byte = 8'd0;
		if (!summary_s2 && rd_ok_s2) begin
			if (cmp_s2) begin
				stored_byte = odd_s2 ? pair_rd[7:0] : pair_rd[15:8];
			end else begin
				stored_byte = raw_rd;
			end
		end
	end

	assign out_valid     = s2_valid_q;
	assign status        = status_s2;
	assign is_summary    = summary_s2;
	assign stored_length = len_s2;
	assign compressed    = cmp_s2;
	assign crc_value     = crc_s2;

`ifndef SYNTHESIS
	a_sum_no_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_summary |-> status != jprc_pkg::ST_RANGE)
		else $error("summary carries a read range status");

	a_cmp_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_summary && compressed |-> status == jprc_pkg::ST_OK
		&& stored_length != '0)
		else $error("compressed summary with bad status or zero length");

	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && is_read |=> out_valid && !is_summary && crc_value == 32'd0)
		else $error("read transfer did not produce a read result");
`endif

endmodule
